// ===== hw/rtl/bsc_pkg.sv =====
package bsc_pkg;

   // Command codes
   typedef enum logic {
      CMD_SINE   = 1'b0,
      CMD_COSINE = 1'b1
   } cmd_type;

   // Angle reduction in unsigned Q.32 with a positive bias
   localparam int RED_W     = 49;
   localparam int RED_STEPS = 14;
   localparam int REM_W     = 35;
   localparam int PI_W      = 34;

   localparam logic [RED_W-1:0] PI_Q32      = RED_W'(64'd13493037705);
   localparam logic [RED_W-1:0] TWO_PI_Q32  = RED_W'(64'd26986075410);
   localparam logic [RED_W-1:0] HALF_PI_Q32 = PI_Q32 >> 1;
   // Bias by 2*pi * 2^13 so every biased angle lies in [0, 2*pi * 2^14)
   localparam logic [RED_W-1:0] RED_BIAS    = TWO_PI_Q32 << (RED_STEPS - 1);

   // Formula in unsigned Q.30
   localparam int Q30_W = 32;
   localparam int P30_W = 34;
   localparam int DEN_W = 36;
   localparam logic [63:0]      PI30_WIDE  = 64'd13493037705 >> 2;
   localparam logic [Q30_W-1:0] PI30       = Q30_W'(PI30_WIDE);
   localparam logic [63:0]      PI30_SQ    = PI30_WIDE * PI30_WIDE;
   localparam logic [63:0]      FIVE_PI_SQ_WIDE = (PI30_SQ >> 30) * 64'd5;
   localparam logic [DEN_W-1:0] FIVE_PI_SQ = DEN_W'(FIVE_PI_SQ_WIDE);

   // Division: dividend is num * 2^14 plus half the divisor
   localparam int FRAC_BITS = 14;
   localparam int QUO_W     = 15;
   localparam int DIV_W     = 51;
   localparam int VAL_W     = 16;
   localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

endpackage

// ===== hw/rtl/bsc_reduce.sv =====
module bsc_reduce import bsc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmd_type                 in_command,
   input  logic signed [31:0]      in_angle,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [REM_W-1:0]        out_rem
);

   logic [RED_W-1:0] rem_ff [RED_STEPS+1];
   logic             vld_ff [RED_STEPS+1];
   logic             rdy    [RED_STEPS+2];
   logic [RED_W-1:0] rem0_in;
   logic [RED_W-1:0] ang_ext;

   assign rdy[RED_STEPS+1] = out_ready;
   assign in_ready         = rdy[0];
   assign out_valid        = vld_ff[RED_STEPS];
   assign out_rem          = rem_ff[RED_STEPS][REM_W-1:0];

   // Scale to Q.32, add the cosine shift and a bias that makes the value positive
   always_comb begin
      ang_ext = RED_W'({{17{in_angle[31]}}, in_angle, 16'd0});
      rem0_in = ang_ext + RED_BIAS;
      if (in_command == CMD_COSINE) begin
         rem0_in = rem0_in + HALF_PI_Q32;
      end
   end

   assign rdy[0] = !vld_ff[0] || rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         rem_ff[0] <= rem0_in;
      end
   end

   // Subtract 2*pi times a falling power of two where it fits, one per stage
   for (genvar s = 1; s <= RED_STEPS; s++) begin : g_step
      localparam logic [RED_W-1:0] STEP_SUB = TWO_PI_Q32 << (RED_STEPS - s);
      logic [RED_W-1:0] rem_in;

      assign rdy[s]  = !vld_ff[s] || rdy[s+1];
      assign rem_in  = (rem_ff[s-1] >= STEP_SUB) ? rem_ff[s-1] - STEP_SUB : rem_ff[s-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         if (rdy[s]) begin
            rem_ff[s] <= rem_in;
         end
      end
   end

endmodule

// ===== hw/rtl/bsc_poly.sv =====
module bsc_poly import bsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [REM_W-1:0]   in_rem,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [DEN_W-1:0]   out_num,
   output logic [DEN_W-1:0]   out_den,
   output logic               out_sign
);

   logic             vld_a_ff, vld_b_ff, vld_c_ff;
   logic             rdy_a, rdy_b, rdy_c;
   logic             sign_a_ff, sign_b_ff, sign_c_ff;
   logic [Q30_W-1:0] y30_ff, diff_ff;
   logic [P30_W-1:0] p30_ff;
   logic [DEN_W-1:0] num_ff, den_ff;

   logic             sign_in;
   logic [PI_W-1:0]  y_in;
   logic [Q30_W-1:0] y30_in;
   logic [63:0]      prod_in;
   logic [P30_W-1:0] p30_in;

   assign rdy_c    = !vld_c_ff || out_ready;
   assign rdy_b    = !vld_b_ff || rdy_c;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // Stage A: subtract pi, keep the sign, take the magnitude
   always_comb begin
      sign_in = in_rem < REM_W'(PI_Q32);
      y_in    = sign_in ? PI_W'(REM_W'(PI_Q32) - in_rem) : PI_W'(in_rem - REM_W'(PI_Q32));
      y30_in  = y_in[PI_W-1:2];
   end

   // Stage B: y * (pi - y) in Q.30
   assign prod_in = {32'd0, y30_ff} * {32'd0, diff_ff};
   assign p30_in  = prod_in[30 +: P30_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         if (rdy_a) vld_a_ff <= in_valid;
         if (rdy_b) vld_b_ff <= vld_a_ff;
         if (rdy_c) vld_c_ff <= vld_b_ff;
      end
      if (rdy_a) begin
         sign_a_ff <= sign_in;
         y30_ff    <= y30_in;
         diff_ff   <= PI30 - y30_in;
      end
      if (rdy_b) begin
         sign_b_ff <= sign_a_ff;
         p30_ff    <= p30_in;
      end
      // Stage C: numerator 16p and divisor 5pi^2 - 4p
      if (rdy_c) begin
         sign_c_ff <= sign_b_ff;
         num_ff    <= DEN_W'({p30_ff, 4'd0});
         den_ff    <= FIVE_PI_SQ - DEN_W'({p30_ff, 2'd0});
      end
   end

   assign out_valid = vld_c_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_sign  = sign_c_ff;

endmodule

// ===== hw/rtl/bsc_divide.sv =====
module bsc_divide import bsc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [DEN_W-1:0]        in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic                    in_sign,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [VAL_W-1:0] out_value
);

   logic [DIV_W-1:0] rem_ff  [QUO_W+1];
   logic [DEN_W-1:0] den_ff  [QUO_W+1];
   logic [QUO_W-1:0] quo_ff  [QUO_W+1];
   logic             sign_ff [QUO_W+1];
   logic             vld_ff  [QUO_W+1];
   logic             rdy     [QUO_W+2];

   logic                    out_vld_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic                    rdy_out;
   logic [QUO_W-1:0]        mag_in;

   assign rdy_out         = !out_vld_ff || out_ready;
   assign rdy[QUO_W+1]    = rdy_out;
   assign rdy[0]          = !vld_ff[0] || rdy[1];
   assign in_ready        = rdy[0];

   // Load dividend with half the divisor added for rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         rem_ff[0]  <= DIV_W'({in_num, {FRAC_BITS{1'b0}}}) + DIV_W'(in_den >> 1);
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         sign_ff[0] <= in_sign;
      end
   end

   // Restoring division, one quotient bit per stage
   for (genvar s = 1; s <= QUO_W; s++) begin : g_bit
      logic [DIV_W-1:0] sub;
      logic             take;

      assign sub    = DIV_W'(den_ff[s-1]) << (QUO_W - s);
      assign take   = rem_ff[s-1] >= sub;
      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         if (rdy[s]) begin
            rem_ff[s]  <= take ? rem_ff[s-1] - sub : rem_ff[s-1];
            den_ff[s]  <= den_ff[s-1];
            quo_ff[s]  <= {quo_ff[s-1][QUO_W-2:0], take};
            sign_ff[s] <= sign_ff[s-1];
         end
      end
   end

   // Limit to one and apply the sign
   assign mag_in = (quo_ff[QUO_W] > ONE_Q14) ? ONE_Q14 : quo_ff[QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (rdy_out) begin
         out_vld_ff <= vld_ff[QUO_W];
      end
      if (rdy_out) begin
         value_ff <= sign_ff[QUO_W] ? VAL_W'(mag_in) : -VAL_W'(mag_in);
      end
   end

   assign out_valid = out_vld_ff;
   assign out_value = value_ff;

endmodule

// ===== hw/rtl/bhaskara_sine_cosine.sv =====
// Channel   | Direction | Handshake            | Payload
// request   | in        | req_valid/req_ready  | req_command[0:0], req_angle[31:0] Q16.16
// response  | out       | rsp_valid/rsp_ready  | rsp_value[15:0] Q2.14
//
// One transaction enters per cycle when the output drains.
// Most of the depth is in the 14-stage modulo reduction and the 15-stage quotient pipeline.
// Synchronous active-high reset clears all valid bits; no state beyond them.
// A stall on rsp_ready holds the stages behind it; empty stages still fill.
module bhaskara_sine_cosine import bsc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic signed [31:0]      req_angle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value
);

   logic             red_valid, red_ready;
   logic [REM_W-1:0] red_rem;
   logic             poly_valid, poly_ready;
   logic [DEN_W-1:0] poly_num, poly_den;
   logic             poly_sign;
   cmd_type          command;

   assign command = cmd_type'(req_command);

   bsc_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_command (command),
      .in_angle   (req_angle),
      .out_valid  (red_valid),
      .out_ready  (red_ready),
      .out_rem    (red_rem)
   );

   bsc_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_rem    (red_rem),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_num   (poly_num),
      .out_den   (poly_den),
      .out_sign  (poly_sign)
   );

   bsc_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .in_num    (poly_num),
      .in_den    (poly_den),
      .in_sign   (poly_sign),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (rsp_value)
   );

endmodule

// ===== hw/rtl/bsc_checker.sv =====
module bsc_checker import bsc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] rsp_value
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response dropped or changed while stalled");

   // Keep results within plus and minus one
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= 16'sd16384) && (rsp_value >= -16'sd16384))
      else $error("response out of range");

   // An empty output stage lets the whole pipeline advance
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bhaskara_sine_cosine bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_value (rsp_value)
);

// ===== verif/tb_top.sv =====
module tb_top import bsc_pkg::*; ();

   localparam int LATENCY     = 35;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint PI_FX      = 64'sd13493037705;
   localparam longint TWO_PI_FX  = 2 * PI_FX;
   localparam longint HALF_PI_FX = PI_FX >>> 1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_command = 1'b0;
   logic signed [31:0]      req_angle = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_value;

   logic signed [15:0] expected_values[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  hold_off_done = 1'b0;
   int  accepted_count = 0;

   bhaskara_sine_cosine uut (.*);

   always #10 clock = ~clock;

   // Predict the Q2.14 sine or cosine for one request
   function automatic logic signed [15:0] predict_bhaskara(cmd_type cmd,
                                                           logic signed [31:0] ang);
      longint          scaled, reduced, offset;
      longint unsigned mag_q32, pi_q30, y_q30, five_pi_sq, prod_q30;
      longint unsigned numer, denom, mag;
      scaled = longint'(ang) * 65536;
      if (cmd == CMD_COSINE) scaled += HALF_PI_FX;
      reduced = scaled % TWO_PI_FX;
      if (reduced < 0) reduced += TWO_PI_FX;
      offset = reduced - PI_FX;
      mag_q32 = (offset < 0) ? longint'(-offset) : offset;
      pi_q30 = longint'(PI_FX) >> 2;
      y_q30 = mag_q32 >> 2;
      if (y_q30 > pi_q30) y_q30 = pi_q30;
      five_pi_sq = ((pi_q30 * pi_q30) >> 30) * 5;
      prod_q30 = (y_q30 * (pi_q30 - y_q30)) >> 30;
      numer = 16 * prod_q30;
      denom = five_pi_sq - 4 * prod_q30;
      mag = ((numer << 14) + (denom >> 1)) / denom;
      if (mag > 16384) mag = 16384;
      return (offset < 0) ? 16'(mag) : -16'(mag);
   endfunction

   // Offer one transaction, honoring the handshake
   task automatic send_angle(cmd_type cmd, logic signed [31:0] ang);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_angle   <= ang;
      expected_values.insert(expected_values.size(), predict_bhaskara(cmd, ang));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_count++;
   endtask

   task automatic idle_sender();
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] ang;
      bit                 known;
      logic signed [15:0] value;
   } stim_row_type;

   // Directed rows: extremes, quadrant points, negative angles, reduced value at pi
   stim_row_type stim_table[] = '{
      '{CMD_SINE,   32'sh0000_0000, 1'b1,  16'sd0},
      '{CMD_COSINE, 32'sh0000_0000, 1'b1,  16'sd16384},
      '{CMD_SINE,   32'sh0001_921F, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'sh0003_243F, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh0003_243F, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh0004_B65F, 1'b0,  16'sd0},
      '{CMD_SINE,   32'shFFFE_6DE1, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'shFFFC_DBC1, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh7FFF_FFFF, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'sh7FFF_FFFF, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh8000_0000, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'sh8000_0000, 1'b0,  16'sd0},
      '{CMD_SINE,   32'shFFFF_FFFF, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'sh0000_0001, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh0000_8000, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'shFFFF_8000, 1'b0,  16'sd0},
      '{CMD_SINE,   32'sh5555_5555, 1'b0,  16'sd0},
      '{CMD_COSINE, 32'shAAAA_AAAA, 1'b0,  16'sd0}
   };

   // Sender
   initial begin
      cmd_type cmd;
      logic signed [31:0] ang;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_table[i]) begin
         if (stim_table[i].known &&
             predict_bhaskara(stim_table[i].cmd, stim_table[i].ang) != stim_table[i].value)
            begin
            $error("predictor row %0d: expected %0d got %0d", i, stim_table[i].value,
                   predict_bhaskara(stim_table[i].cmd, stim_table[i].ang));
            error_count++;
         end
         send_angle(stim_table[i].cmd, stim_table[i].ang);
         idle_sender();
      end
      for (int n = 0; n < 950; n++) begin
         cmd = cmd_type'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: ang = $urandom;
            1: ang = $signed(32'($urandom_range(0, 32'h0007_0000))) - 32'sh0003_8000;
            2: ang = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: ang = $signed(32'($urandom_range(0, 32'h000C_0000))) - 32'sh0006_0000;
         endcase
         send_angle(cmd, ang);
         idle_sender();
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: random stalls plus one long hold-off to back up the pipeline
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!hold_off_done && accepted_count > 60) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_off_done = 1'b1;
         end
         stall = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $error("unexpected result: value %0d", rsp_value);
            error_count++;
         end else begin
            want = expected_values.pop_front();
            if (rsp_value !== want) begin
               $error("value mismatch: expected %0d actual %0d", want, rsp_value);
               error_count++;
            end
         end
      end
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Drain and report
   initial begin
      wait (stimulus_done);
      while (expected_values.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && expected_values.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_reduce.sv
hw/rtl/bsc_poly.sv
hw/rtl/bsc_divide.sv
hw/rtl/bhaskara_sine_cosine.sv
hw/rtl/bsc_checker.sv
verif/tb_top.sv
